@@ hdl/rlpse_pkg.sv @@
// Shared types, register codes and the tangent table for the LED symbol encoder.
package rlpse_pkg;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS    = 2'd0,
    CFG_ONE_DUTY      = 2'd1,
    CFG_ZERO_DUTY     = 2'd2,
    CFG_RESET_SYMBOLS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_EOF   = 1'b1
  } op_e;

  localparam logic [6:0] BRIGHT_MAX      = 7'd100;
  localparam logic [6:0] DUTY_MAX        = 7'd89;
  localparam logic [6:0] RESET_SYM_MIN   = 7'd1;
  localparam logic [6:0] RESET_SYM_MAX   = 7'd64;
  localparam logic [6:0] BRIGHT_RST      = 7'd100;
  localparam logic [6:0] ONE_DUTY_RST    = 7'd60;
  localparam logic [6:0] ZERO_DUTY_RST   = 7'd30;
  localparam logic [6:0] RESET_SYM_RST   = 7'd45;
  localparam logic [6:0] SYMS_PER_PIXEL  = 7'd24;
  localparam int         NUM_LANES       = 3;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [6:0] duty;
    logic       last;
  } symbol_t;

  typedef struct packed {
    logic [6:0] one_duty;
    logic [6:0] zero_duty;
    logic [6:0] reset_symbols;
  } sym_cfg_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] count;
  } ser_status_t;

  // round(tan(k degrees) * 2^16) for k = 0..45.
  function automatic logic [16:0] tan_q16(input logic [5:0] k);
    logic [16:0] t;
    case (k)
      6'd0:  t = 17'd0;     6'd1:  t = 17'd1144;  6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;  6'd4:  t = 17'd4583;  6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;  6'd7:  t = 17'd8047;  6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380; 6'd10: t = 17'd11556; 6'd11: t = 17'd12739;
      6'd12: t = 17'd13930; 6'd13: t = 17'd15130; 6'd14: t = 17'd16340;
      6'd15: t = 17'd17560; 6'd16: t = 17'd18792; 6'd17: t = 17'd20036;
      6'd18: t = 17'd21294; 6'd19: t = 17'd22566; 6'd20: t = 17'd23853;
      6'd21: t = 17'd25157; 6'd22: t = 17'd26478; 6'd23: t = 17'd27818;
      6'd24: t = 17'd29179; 6'd25: t = 17'd30560; 6'd26: t = 17'd31964;
      6'd27: t = 17'd33392; 6'd28: t = 17'd34846; 6'd29: t = 17'd36327;
      6'd30: t = 17'd37837; 6'd31: t = 17'd39378; 6'd32: t = 17'd40951;
      6'd33: t = 17'd42560; 6'd34: t = 17'd44205; 6'd35: t = 17'd45889;
      6'd36: t = 17'd47615; 6'd37: t = 17'd49385; 6'd38: t = 17'd51202;
      6'd39: t = 17'd53070; 6'd40: t = 17'd54991; 6'd41: t = 17'd56970;
      6'd42: t = 17'd59009; 6'd43: t = 17'd61113; 6'd44: t = 17'd63287;
      6'd45: t = 17'd65536;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

endpackage

@@ hdl/rlpse_lane.sv @@
// One color lane: scales a channel byte by the brightness factor and saturates.
module rlpse_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic [7:0]         chan_i,
  input  logic [FRAC_BITS:0] scale_i,
  output logic [7:0]         level_o
);

  logic [FRAC_BITS+8:0] prod;
  logic [8:0]           whole;

  assign prod    = (FRAC_BITS + 9)'(chan_i) * (FRAC_BITS + 9)'(scale_i);
  assign whole   = prod[FRAC_BITS+8:FRAC_BITS];
  assign level_o = (whole > 9'd255) ? 8'hFF : whole[7:0];

endmodule

@@ hdl/rlpse_serial.sv @@
// Merges the lane levels into one word and shifts it out as duty symbols.
module rlpse_serial (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  rlpse_pkg::op_e        opcode_i,
  input  logic [23:0]           word_i,
  input  rlpse_pkg::sym_cfg_t   cfg_i,
  input  logic                  out_ready_i,
  output logic                  can_load_o,
  output logic                  emit_o,
  output rlpse_pkg::symbol_t    sym_o,
  output rlpse_pkg::ser_status_t status_o
);
  import rlpse_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [23:0] word_q, word_d;
  op_e         op_q, op_d;
  logic        final_sym;

  assign emit_o     = busy_q && out_ready_i;
  assign final_sym  = emit_o && (cnt_q == 7'd1);
  assign can_load_o = !busy_q || final_sym;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    word_d = word_q;
    op_d   = op_q;
    if (load_i) begin
      busy_d = 1'b1;
      word_d = word_i;
      op_d   = opcode_i;
      cnt_d  = (opcode_i == OP_EOF) ? cfg_i.reset_symbols : SYMS_PER_PIXEL;
    end else if (emit_o) begin
      busy_d = !final_sym;
      cnt_d  = cnt_q - 7'd1;
      word_d = {word_q[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    op_q   <= op_d;
  end

  always_comb begin
    if (op_q == OP_EOF) begin
      sym_o.duty = 7'd0;
    end else begin
      sym_o.duty = word_q[23] ? cfg_i.one_duty : cfg_i.zero_duty;
    end
    sym_o.last = (cnt_q == 7'd1);
  end

  assign status_o.busy  = busy_q;
  assign status_o.count = cnt_q;

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (busy_q && cnt_q != 7'd0))
    else $error("serializer did not start after a load");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 7'd0 && cnt_q <= RESET_SYM_MAX))
    else $error("symbol count out of range while busy");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && !final_sym) |=> busy_q)
    else $error("serializer went idle before its final symbol");
  a_eof_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == OP_EOF) |-> (sym_o.duty == 7'd0))
    else $error("end-of-frame symbol with nonzero duty");
`endif

endmodule

@@ hdl/rgb_led_pwm_symbol_encoder_top.sv @@
// Top level of the LED PWM symbol encoder: config registers, color lanes, serializer.
//
//   channel | direction | payload         | handshake
//   --------+-----------+-----------------+------------------------------------
//   in      | request   | pixel_req_t     | in_valid_i / in_stall_o
//   out     | result    | symbol_t        | out_valid_o / out_stall_i
//   cfg     | write     | 7-bit data      | cfg_we_i, cfg_index_i
//
// A pixel request yields 24 symbols, one per cycle; an end-of-frame request yields
// reset_symbols symbols (1..64). The serializer sets that rate; an output stall pauses it.
// The next request is taken in the cycle its predecessor's final symbol goes out, so
// requests follow without a gap. A registered output stage holds a symbol under stall.
// Reset restores brightness 100, one duty 60, zero duty 30 and 45 reset symbols.
module rgb_led_pwm_symbol_encoder_top #(
  parameter int SCALE_FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rlpse_pkg::pixel_req_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rlpse_pkg::symbol_t    out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [6:0]            cfg_data_i
);
  import rlpse_pkg::*;

  localparam int SW = SCALE_FRACTION_BITS + 1;
  localparam int TW = ((SCALE_FRACTION_BITS > 16) ? SCALE_FRACTION_BITS : 16) + 2;

  logic [6:0]   bright_q, one_q, zero_q, rsym_q;
  logic [6:0]   bright_d;
  logic [9:0]   bright9;
  logic [21:0]  kprod;
  logic [5:0]   kdeg;
  logic [TW-1:0] tan_ext;
  logic [SW-1:0] scale_d, scale_q;

  logic [NUM_LANES-1:0][7:0] chan;
  logic [NUM_LANES-1:0][7:0] level;

  sym_cfg_t    sym_cfg;
  symbol_t     sym, out_q;
  ser_status_t ser_status;
  logic        out_valid_q, out_ready, can_load, emit, in_accept;

  always_comb begin
    bright_d = bright_q;
    if (cfg_we_i && (cfg_reg_e'(cfg_index_i) == CFG_BRIGHTNESS)) begin
      bright_d = (cfg_data_i > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data_i;
    end
  end

  // Configuration writes, saturated to each register's range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RST;
      one_q    <= ONE_DUTY_RST;
      zero_q   <= ZERO_DUTY_RST;
      rsym_q   <= RESET_SYM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BRIGHTNESS:    bright_q <= bright_d;
        CFG_ONE_DUTY:      one_q    <= (cfg_data_i > DUTY_MAX) ? DUTY_MAX : cfg_data_i;
        CFG_ZERO_DUTY:     zero_q   <= (cfg_data_i > DUTY_MAX) ? DUTY_MAX : cfg_data_i;
        CFG_RESET_SYMBOLS: begin
          if (cfg_data_i < RESET_SYM_MIN) begin
            rsym_q <= RESET_SYM_MIN;
          end else if (cfg_data_i > RESET_SYM_MAX) begin
            rsym_q <= RESET_SYM_MAX;
          end else begin
            rsym_q <= cfg_data_i;
          end
        end
        default: ;
      endcase
    end
  end

  // Angle in degrees is brightness*9/20; the divide by 20 is a reciprocal multiply
  // by 3277/2^16, exact for brightness up to 100. The factor follows the brightness
  // being written, so it is current in the same cycle as the register.
  assign bright9 = 10'(bright_d) * 10'd9;
  assign kprod   = 22'(bright9) * 22'd3277;
  assign kdeg    = kprod[21:16];
  assign tan_ext = TW'(tan_q16(kdeg));

  if (SCALE_FRACTION_BITS >= 16) begin : g_scale_up
    assign scale_d = SW'(tan_ext << (SCALE_FRACTION_BITS - 16));
  end else begin : g_scale_round
    assign scale_d = SW'((tan_ext + (TW'(1) << (15 - SCALE_FRACTION_BITS)))
                         >> (16 - SCALE_FRACTION_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SW'(1) << SCALE_FRACTION_BITS;
    end else begin
      scale_q <= scale_d;
    end
  end

  assign chan[2] = in_data_i.green;
  assign chan[1] = in_data_i.red;
  assign chan[0] = in_data_i.blue;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rlpse_lane #(
      .FRAC_BITS(SCALE_FRACTION_BITS)
    ) u_lane (
      .chan_i (chan[g]),
      .scale_i(scale_q),
      .level_o(level[g])
    );
  end

  assign sym_cfg.one_duty      = one_q;
  assign sym_cfg.zero_duty     = zero_q;
  assign sym_cfg.reset_symbols = rsym_q;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !can_load;
  assign in_accept  = in_valid_i && can_load;

  rlpse_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .opcode_i   (in_data_i.opcode),
    .word_i     (level),
    .cfg_i      (sym_cfg),
    .out_ready_i(out_ready),
    .can_load_o (can_load),
    .emit_o     (emit),
    .sym_o      (sym),
    .status_o   (ser_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= sym;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pixel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.opcode == OP_PIXEL) |=> (ser_status.count == SYMS_PER_PIXEL))
    else $error("pixel request did not load 24 symbols");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && ser_status.busy) |-> (emit && sym.last))
    else $error("request taken while serializer still had symbols");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted symbol did not reach the output register");
`endif

endmodule

@@ sim/encoder_checker.sv @@
// Scoreboard for the LED symbol encoder: predicts duty symbols and compares them.
`timescale 1ns / 1ps

module encoder_checker #(
  parameter int SCALE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  rlpse_pkg::pixel_req_t in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  rlpse_pkg::symbol_t    out_data_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [6:0]            cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);
  import rlpse_pkg::*;

  // tan(k degrees) in unsigned Q16, k = 0..45.
  int unsigned tan_lut [46] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047,
    9210, 10380, 11556, 12739, 13930, 15130, 16340, 17560,
    18792, 20036, 21294, 22566, 23853, 25157, 26478, 27818,
    29179, 30560, 31964, 33392, 34846, 36327, 37837, 39378,
    40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
    54991, 56970, 59009, 61113, 63287, 65536
  };

  logic [6:0] bright_pct;
  logic [6:0] one_code;
  logic [6:0] zero_code;
  logic [6:0] reset_len;
  symbol_t    symbol_q [$];
  symbol_t    want_sym;

  function automatic longint unsigned dim_factor();
    int unsigned      k;
    longint unsigned  t;
    k = (int'(bright_pct) * 45) / 100;
    if (k > 45) begin
      k = 45;
    end
    t = tan_lut[k];
    if (SCALE_BITS >= 16) begin
      return t << (SCALE_BITS - 16);
    end
    // Narrower factors are rounded half up from the Q16 entry.
    return (t + (64'd1 << (15 - SCALE_BITS))) >> (16 - SCALE_BITS);
  endfunction

  function automatic logic [7:0] dim_channel(logic [7:0] level, longint unsigned factor);
    longint unsigned prod;
    prod = (longint'(level) * factor) >> SCALE_BITS;
    return (prod > 255) ? 8'hFF : prod[7:0];
  endfunction

  function automatic void encode_request(pixel_req_t req);
    longint unsigned factor;
    logic [23:0]     word;
    symbol_t         sym;
    if (req.opcode == OP_EOF) begin
      for (int i = 0; i < int'(reset_len); i++) begin
        sym.duty = 7'd0;
        sym.last = (i == int'(reset_len) - 1);
        symbol_q.push_back(sym);
      end
    end else begin
      factor = dim_factor();
      word = {dim_channel(req.green, factor), dim_channel(req.red, factor),
              dim_channel(req.blue, factor)};
      for (int i = 0; i < 24; i++) begin
        sym.duty = word[23 - i] ? one_code : zero_code;
        sym.last = (i == 23);
        symbol_q.push_back(sym);
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_pct = BRIGHT_RST;
      one_code   = ONE_DUTY_RST;
      zero_code  = ZERO_DUTY_RST;
      reset_len  = RESET_SYM_RST;
      symbol_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_BRIGHTNESS: begin
            bright_pct = (cfg_data_i > BRIGHT_MAX) ? BRIGHT_MAX : cfg_data_i;
          end
          CFG_ONE_DUTY: begin
            one_code = (cfg_data_i > DUTY_MAX) ? DUTY_MAX : cfg_data_i;
          end
          CFG_ZERO_DUTY: begin
            zero_code = (cfg_data_i > DUTY_MAX) ? DUTY_MAX : cfg_data_i;
          end
          default: begin
            if (cfg_data_i < RESET_SYM_MIN) begin
              reset_len = RESET_SYM_MIN;
            end else if (cfg_data_i > RESET_SYM_MAX) begin
              reset_len = RESET_SYM_MAX;
            end else begin
              reset_len = cfg_data_i;
            end
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        encode_request(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (symbol_q.size() == 0) begin
          report_mismatch($sformatf("symbol duty=%0d last=%0b with nothing outstanding",
                                    out_data_i.duty, out_data_i.last));
        end else begin
          want_sym = symbol_q.pop_front();
          checked_o++;
          if (out_data_i.duty !== want_sym.duty) begin
            report_mismatch($sformatf("duty got %0d, want %0d", out_data_i.duty,
                                      want_sym.duty));
          end
          if (out_data_i.last !== want_sym.last) begin
            report_mismatch($sformatf("last got %0b, want %0b", out_data_i.last,
                                      want_sym.last));
          end
        end
      end
      pending_o = symbol_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// Top of the LED symbol encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import rlpse_pkg::*;

  localparam int SCALE_BITS  = 16;
  localparam int LONG_HOLD   = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RAND_PHASES = 4;
  localparam int RAND_ITEMS  = 50;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pixel_req_t in_data;
  logic       out_valid;
  logic       out_stall;
  symbol_t    out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  int  errors;
  int  pending;
  int  checked;
  int  pixel_cnt;
  int  frame_cnt;
  int  setting_cnt;
  bit  want_long_hold;

  rgb_led_pwm_symbol_encoder_top #(
    .SCALE_FRACTION_BITS(SCALE_BITS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  encoder_checker #(
    .SCALE_BITS(SCALE_BITS)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: runs of free flow, light and heavy stalling, plus one long hold-off.
  initial begin
    int  run;
    int  mode;
    bit  hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (want_long_hold && !hold_done) begin
        hold_done = 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      mode = $urandom_range(0, 2);
      run  = $urandom_range(1, 40);
      for (int c = 0; c < run; c++) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(0, 1);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no request or symbol moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Holds valid high on return so that back-to-back requests need no toggle.
  task automatic send_request(op_e op, logic [7:0] g, logic [7:0] r, logic [7:0] b);
    pixel_req_t req;
    req.opcode = op;
    req.green  = g;
    req.red    = r;
    req.blue   = b;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    if (op == OP_EOF) begin
      frame_cnt++;
    end else begin
      pixel_cnt++;
    end
  endtask

  task automatic close_phase();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_settings(logic [6:0] bright, logic [6:0] one, logic [6:0] zero,
                                logic [6:0] syms);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_data  <= bright;
    @(negedge clk);
    cfg_index <= CFG_ONE_DUTY;
    cfg_data  <= one;
    @(negedge clk);
    cfg_index <= CFG_ZERO_DUTY;
    cfg_data  <= zero;
    @(negedge clk);
    cfg_index <= CFG_RESET_SYMBOLS;
    cfg_data  <= syms;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_cnt++;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_burst_train(int count);
    int  sent;
    int  burst;
    int  gap;
    op_e op;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && sent < count; j++) begin
        op = ($urandom_range(0, 7) == 0) ? OP_EOF : OP_PIXEL;
        send_request(op, pick_level(), pick_level(), pick_level());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BRIGHTNESS;
    cfg_data       = 7'd0;
    want_long_hold = 1'b0;
    pixel_cnt      = 0;
    frame_cnt      = 0;
    setting_cnt    = 0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: full brightness, default duties, 45-symbol line reset.
    send_request(OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_PIXEL, 8'hAA, 8'h55, 8'h0F);
    send_request(OP_PIXEL, 8'h01, 8'h80, 8'hFE);
    send_request(OP_EOF, 8'hFF, 8'hFF, 8'hFF);
    close_phase();

    // Every register written out of range so that each one saturates.
    write_settings(7'd127, 7'd127, 7'd127, 7'd0);
    send_request(OP_PIXEL, 8'h80, 8'h01, 8'hFF);
    send_request(OP_EOF, 8'h00, 8'h00, 8'h00);
    close_phase();

    // Zero brightness blanks every channel; longest line reset.
    write_settings(7'd0, 7'd0, 7'd89, 7'd64);
    send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_EOF, 8'h5A, 8'hA5, 8'h3C);
    close_phase();

    write_settings(7'd99, 7'd89, 7'd0, 7'd127);
    send_request(OP_PIXEL, 8'hFF, 8'hC0, 8'h7F);
    send_request(OP_PIXEL, 8'h12, 8'h34, 8'h56);
    send_request(OP_EOF, 8'h00, 8'h00, 8'h00);
    close_phase();

    write_settings(7'd1, 7'd1, 7'd88, 7'd2);
    send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_EOF, 8'h00, 8'h00, 8'h00);
    close_phase();

    write_settings(7'd50, 7'd60, 7'd30, 7'd45);
    send_request(OP_PIXEL, 8'hFF, 8'h80, 8'h40);
    send_request(OP_EOF, 8'h00, 8'h00, 8'h00);
    send_request(OP_PIXEL, 8'h03, 8'h07, 8'h01);
    close_phase();

    write_settings(7'd3, 7'd45, 7'd44, 7'd1);
    send_request(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    close_phase();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_settings(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      // The first random phase runs against a long receiver hold-off.
      if (p == 0) begin
        want_long_hold = 1'b1;
      end
      send_random_burst_train(RAND_ITEMS);
      close_phase();
    end

    repeat (8) @(negedge clk);

    $display("Run covered %0d pixel and %0d end-of-frame requests under %0d settings.",
             pixel_cnt, frame_cnt, setting_cnt + 1);
    $display("Compared %0d duty symbols, %0d mismatches.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rlpse_pkg.sv
hdl/rlpse_lane.sv
hdl/rlpse_serial.sv
hdl/rgb_led_pwm_symbol_encoder_top.sv
sim/encoder_checker.sv
sim/testbench.sv
